>>> rtl/wav_header_parser_sample_extractor_top_assert.svh
// assertion macros for the wav header parser
`ifndef WAV_HEADER_PARSER_SAMPLE_EXTRACTOR_TOP_ASSERT_SVH
`define WAV_HEADER_PARSER_SAMPLE_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define WAVPCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define WAVPCM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WAVPCM_ASSERT(lbl, prop, msg)
`define WAVPCM_ASSERT_RST(lbl, prop, msg)

`endif

`endif

>>> rtl/wavpcm_pkg.sv
package wavpcm_pkg;

	// chunk tags as little-endian words
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// fmt chunk: fields taken from its first twelve bytes
	localparam logic [31:0] FMT_BYTES = 32'd12;
	localparam logic [3:0]  FMT_LAST  = 4'd11;

	// register reset values
	localparam logic [31:0] RATE_RESET     = 32'd44100;
	localparam logic [15:0] CHANNELS_RESET = 16'd2;

	// configuration register indexes
	localparam logic CFG_RATE     = 1'b0;
	localparam logic CFG_CHANNELS = 1'b1;

	typedef enum logic [3:0] {
		PH_RIFF,
		PH_RSIZE,
		PH_WAVE,
		PH_CTAG,
		PH_CLEN,
		PH_FMT,
		PH_SKIP,
		PH_PAD,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		EV_HEADER,
		EV_SAMPLE,
		EV_ERROR
	} event_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_TAG,
		ST_BAD_FMT,
		ST_NO_DATA
	} status_t;

endpackage

>>> rtl/wav_header_parser_sample_extractor_top.sv
// a byte accepted into the input register has its transaction shown on out_valid from the result register
// throughput: one byte per cycle, held up only by backpressure on the output
// rate set by the single parse step between the input register and the result register
// reset: arst_n low clears the pipeline and parser state, registers return to 44100 Hz, 2 ch
// after an error or the last sample every further byte is taken and dropped until reset
`include "wav_header_parser_sample_extractor_top_assert.svh"

module wav_header_parser_sample_extractor_top
	import wavpcm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               end_of_file,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_res,
	output logic [1:0]         status,
	output logic signed [15:0] sample,
	output logic [31:0]        data_bytes,
	output logic [31:0]        byte_rate,
	output logic               final_sample
);

	// configuration
	logic [31:0] req_rate_q;
	logic [15:0] req_chan_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;
	logic        adv;

	// parser state
	phase_t      phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] brate_q, brate_d;
	logic [31:0] remain_q, remain_d;
	logic [7:0]  low_q, low_d;

	// step results
	logic               res_v;
	event_t             res_ev;
	status_t            res_st;
	logic signed [15:0] res_smp;
	logic [31:0]        res_db;
	logic [31:0]        res_br;
	logic               res_fin;

	logic        take_last;
	logic [31:0] full_tag;
	logic [31:0] full_len;
	logic [31:0] skip_len;
	logic [3:0]  fmt_idx;
	logic        skip_done;
	logic        tag_restart;

	// output register
	logic               out_valid_q;
	logic [1:0]         ev_q;
	logic [1:0]         st_q;
	logic signed [15:0] smp_q;
	logic [31:0]        db_q;
	logic [31:0]        br_q;
	logic               fin_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_rate_q <= RATE_RESET;
			req_chan_q <= CHANNELS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RATE:     req_rate_q <= cfg_data;
				CFG_CHANNELS: req_chan_q <= cfg_data[15:0];
				default:      req_rate_q <= req_rate_q;
			endcase
		end
	end

	// pipeline flow
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	// field assembly helpers
	assign take_last = (cnt_q[1:0] == 2'd3);
	assign full_tag  = {byte_s1, tag_q[23:0]};
	assign full_len  = {byte_s1, len_q[23:0]};
	assign fmt_idx   = cnt_q[3:0];
	assign skip_len  = (len_q > FMT_BYTES) ? (len_q - FMT_BYTES) : '0;

	// one parse step per byte
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		tag_d       = tag_q;
		len_d       = len_q;
		rate_d      = rate_q;
		chan_d      = chan_q;
		brate_d     = brate_q;
		remain_d    = remain_q;
		low_d       = low_q;
		res_v       = 1'b0;
		res_ev      = EV_ERROR;
		res_st      = ST_OK;
		res_smp     = '0;
		res_db      = '0;
		res_br      = '0;
		res_fin     = 1'b0;
		skip_done   = 1'b0;
		tag_restart = 1'b0;

		unique case (phase_q)
			PH_RIFF: begin
				tag_d[{cnt_q[1:0], 3'b000} +: 8] = byte_s1;
				cnt_d = cnt_q + 32'd1;
				if (take_last) begin
					cnt_d = '0;
					if (full_tag != TAG_RIFF) begin
						phase_d = PH_DONE;
						res_v   = 1'b1;
						res_st  = ST_BAD_TAG;
					end else begin
						len_d   = '0;
						phase_d = PH_RSIZE;
					end
				end
			end
			PH_RSIZE: begin
				len_d[{cnt_q[1:0], 3'b000} +: 8] = byte_s1;
				cnt_d = cnt_q + 32'd1;
				if (take_last) begin
					cnt_d   = '0;
					tag_d   = '0;
					phase_d = PH_WAVE;
				end
			end
			PH_WAVE: begin
				tag_d[{cnt_q[1:0], 3'b000} +: 8] = byte_s1;
				cnt_d = cnt_q + 32'd1;
				if (take_last) begin
					cnt_d = '0;
					if (full_tag != TAG_WAVE) begin
						phase_d = PH_DONE;
						res_v   = 1'b1;
						res_st  = ST_BAD_TAG;
					end else begin
						tag_restart = 1'b1;
					end
				end
			end
			PH_CTAG: begin
				tag_d[{cnt_q[1:0], 3'b000} +: 8] = byte_s1;
				cnt_d = cnt_q + 32'd1;
				if (take_last) begin
					cnt_d   = '0;
					len_d   = '0;
					phase_d = PH_CLEN;
				end
			end
			PH_CLEN: begin
				len_d[{cnt_q[1:0], 3'b000} +: 8] = byte_s1;
				cnt_d = cnt_q + 32'd1;
				if (take_last) begin
					cnt_d = '0;
					if (tag_q == TAG_FMT) begin
						chan_d  = '0;
						rate_d  = '0;
						brate_d = '0;
						phase_d = PH_FMT;
					end else if (tag_q == TAG_DATA) begin
						res_v = 1'b1;
						if (full_len == '0 || brate_q == '0) begin
							phase_d = PH_DONE;
							res_st  = ST_NO_DATA;
						end else begin
							remain_d = full_len;
							phase_d  = (full_len[31:1] == '0 || eof_s1) ? PH_DONE : PH_DATA;
							res_ev   = EV_HEADER;
							res_db   = full_len;
							res_br   = brate_q;
						end
					end else if (full_len == '0) begin
						skip_done = 1'b1;
					end else begin
						cnt_d   = full_len;
						phase_d = PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				// byte 0..1 format tag, 2..3 channels, 4..7 rate, 8..11 byte rate
				if (fmt_idx == 4'd2 || fmt_idx == 4'd3) begin
					chan_d[{fmt_idx[0], 3'b000} +: 8] = byte_s1;
				end else if (fmt_idx[3:2] == 2'b01) begin
					rate_d[{fmt_idx[1:0], 3'b000} +: 8] = byte_s1;
				end else if (fmt_idx[3:2] == 2'b10) begin
					brate_d[{fmt_idx[1:0], 3'b000} +: 8] = byte_s1;
				end
				cnt_d = cnt_q + 32'd1;
				if (fmt_idx == FMT_LAST) begin
					if (rate_q != req_rate_q || chan_q != req_chan_q) begin
						phase_d = PH_DONE;
						res_v   = 1'b1;
						res_st  = ST_BAD_FMT;
					end else if (skip_len == '0) begin
						skip_done = 1'b1;
					end else begin
						cnt_d   = skip_len;
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				cnt_d = cnt_q - 32'd1;
				if (cnt_q == 32'd1) begin
					skip_done = 1'b1;
				end
			end
			PH_PAD: begin
				tag_restart = 1'b1;
			end
			PH_DATA: begin
				remain_d = remain_q - 32'd1;
				if (!cnt_q[0]) begin
					low_d = byte_s1;
					cnt_d = 32'd1;
					if (remain_q == 32'd1 || eof_s1) begin
						phase_d = PH_DONE;
					end
				end else begin
					cnt_d   = '0;
					res_v   = 1'b1;
					res_ev  = EV_SAMPLE;
					res_smp = {byte_s1, low_q};
					res_fin = (remain_d[31:1] == '0) || eof_s1;
					if (res_fin) begin
						phase_d = PH_DONE;
					end
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		// end of a skipped chunk: pad byte on odd length, else next tag
		if (skip_done) begin
			if (len_d[0]) begin
				phase_d = PH_PAD;
			end else begin
				tag_restart = 1'b1;
			end
		end
		if (tag_restart) begin
			tag_d   = '0;
			cnt_d   = '0;
			phase_d = PH_CTAG;
		end

		// file ended before the data chunk
		if (eof_s1 && !res_v && phase_d != PH_DONE && phase_d != PH_DATA) begin
			res_v   = 1'b1;
			res_ev  = EV_ERROR;
			res_st  = (phase_d == PH_RIFF || phase_d == PH_RSIZE || phase_d == PH_WAVE) ?
				ST_BAD_TAG : ST_NO_DATA;
			phase_d = PH_DONE;
		end
	end

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RIFF;
			cnt_q    <= '0;
			tag_q    <= '0;
			len_q    <= '0;
			rate_q   <= '0;
			chan_q   <= '0;
			brate_q  <= '0;
			remain_q <= '0;
			low_q    <= '0;
		end else if (valid_s1 && adv) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			tag_q    <= tag_d;
			len_q    <= len_d;
			rate_q   <= rate_d;
			chan_q   <= chan_d;
			brate_q  <= brate_d;
			remain_q <= remain_d;
			low_q    <= low_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && res_v) begin
			ev_q  <= res_ev;
			st_q  <= res_st;
			smp_q <= res_smp;
			db_q  <= res_db;
			br_q  <= res_br;
			fin_q <= res_fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = ev_q;
	assign status       = st_q;
	assign sample       = smp_q;
	assign data_bytes   = db_q;
	assign byte_rate    = br_q;
	assign final_sample = fin_q;

	// checks
	`WAVPCM_ASSERT_RST(a_reset_quiet, !arst_n |=> !out_valid_q && !valid_s1, "transaction during reset")
	`WAVPCM_ASSERT(a_done_sticky, phase_q == PH_DONE |=> phase_q == PH_DONE, "parser left done")
	`WAVPCM_ASSERT(a_err_status, out_valid && event_res == EV_ERROR |-> status != ST_OK, "error without status")
	`WAVPCM_ASSERT(a_fin_sample, out_valid && final_sample |-> event_res == EV_SAMPLE, "final flag off sample")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import wavpcm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD_AT = 200;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int QUIET_TAIL = 150;
	localparam int MAX_PRINTS = 40;

	// one byte of the file stream as offered to the block
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} file_byte_t;

	// one result transaction
	typedef struct packed {
		event_t             kind;
		status_t            code;
		logic signed [15:0] smp;
		logic [31:0]        nbytes;
		logic [31:0]        brate;
		logic               fin;
	} wav_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic               cfg_index = CFG_RATE;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         data_byte = '0;
	logic               end_of_file = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         event_res;
	logic [1:0]         status;
	logic signed [15:0] sample;
	logic [31:0]        data_bytes;
	logic [31:0]        byte_rate;
	logic               final_sample;

	file_byte_t  file_q[$];
	wav_result_t results_q[$];
	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;
	bit          quiet = 1'b0;

	// parser copy: registers and state
	logic [31:0] want_rate = RATE_RESET;
	logic [15:0] want_channels = CHANNELS_RESET;
	phase_t      ph = PH_RIFF;
	logic [31:0] fcount = '0;
	logic [31:0] fshift = '0;
	logic [31:0] ctag = '0;
	logic [31:0] clen = '0;
	logic [31:0] fmt_rate = '0;
	logic [15:0] fmt_channels = '0;
	logic [31:0] fmt_byte_rate = '0;
	logic [31:0] data_left = '0;
	logic [7:0]  lo_byte = '0;

	wav_result_t predicted;
	wav_result_t oldest;

	wav_header_parser_sample_extractor_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_file  (end_of_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.status       (status),
		.sample       (sample),
		.data_bytes   (data_bytes),
		.byte_rate    (byte_rate),
		.final_sample (final_sample)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// little-endian 4-byte field accumulate, true once the field is full
	function automatic bit add_field_byte(inout logic [31:0] acc, input logic [7:0] b);
		acc = acc | (32'(b) << (fshift & 32'd24));
		fshift = fshift + 32'd8;
		fcount = fcount + 32'd1;
		if (fcount >= 32'd4) begin
			fcount = '0;
			fshift = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void next_tag();
		ctag = '0;
		fcount = '0;
		fshift = '0;
		ph = PH_CTAG;
	endfunction

	// odd chunk lengths are followed by one pad byte
	function automatic void after_skip();
		if (clen[0])
			ph = PH_PAD;
		else
			next_tag();
	endfunction

	function automatic void start_skip(logic [31:0] len);
		if (len == '0) begin
			after_skip();
		end else begin
			fcount = len;
			ph = PH_SKIP;
		end
	endfunction

	function automatic wav_result_t fail_result(status_t s);
		wav_result_t r;
		r = '0;
		r.kind = EV_ERROR;
		r.code = s;
		ph = PH_DONE;
		return r;
	endfunction

	// advance the parser by one byte, true when the byte yields a transaction
	function automatic bit parse_byte(input logic [7:0] b, input logic eof,
			output wav_result_t r);
		logic [31:0] idx;
		bit          fin;
		r = '0;
		case (ph)
			PH_RIFF: begin
				if (add_field_byte(ctag, b)) begin
					if (ctag != TAG_RIFF) begin
						r = fail_result(ST_BAD_TAG);
						return 1'b1;
					end
					clen = '0;
					ph = PH_RSIZE;
				end
			end
			PH_RSIZE: begin
				if (add_field_byte(clen, b)) begin
					ctag = '0;
					ph = PH_WAVE;
				end
			end
			PH_WAVE: begin
				if (add_field_byte(ctag, b)) begin
					if (ctag != TAG_WAVE) begin
						r = fail_result(ST_BAD_TAG);
						return 1'b1;
					end
					next_tag();
				end
			end
			PH_CTAG: begin
				if (add_field_byte(ctag, b)) begin
					clen = '0;
					ph = PH_CLEN;
				end
			end
			PH_CLEN: begin
				if (add_field_byte(clen, b)) begin
					if (ctag == TAG_FMT) begin
						fmt_channels = '0;
						fmt_rate = '0;
						fmt_byte_rate = '0;
						fcount = '0;
						ph = PH_FMT;
					end else if (ctag == TAG_DATA) begin
						if (clen == '0 || fmt_byte_rate == '0) begin
							r = fail_result(ST_NO_DATA);
							return 1'b1;
						end
						data_left = clen;
						fcount = '0;
						ph = (data_left < 32'd2 || eof) ? PH_DONE : PH_DATA;
						r.kind = EV_HEADER;
						r.code = ST_OK;
						r.nbytes = clen;
						r.brate = fmt_byte_rate;
						return 1'b1;
					end else begin
						start_skip(clen);
					end
				end
			end
			PH_FMT: begin
				// channels at bytes 2..3, rate at 4..7, byte rate at 8..11
				idx = fcount;
				if (idx == 32'd2 || idx == 32'd3)
					fmt_channels = fmt_channels | (16'(b) << ((idx - 32'd2) * 8));
				else if (idx >= 32'd4 && idx <= 32'd7)
					fmt_rate = fmt_rate | (32'(b) << ((idx - 32'd4) * 8));
				else if (idx >= 32'd8 && idx <= 32'd11)
					fmt_byte_rate = fmt_byte_rate | (32'(b) << ((idx - 32'd8) * 8));
				fcount = idx + 32'd1;
				if (fcount >= FMT_BYTES) begin
					if (fmt_rate != want_rate || fmt_channels != want_channels) begin
						r = fail_result(ST_BAD_FMT);
						return 1'b1;
					end
					start_skip(clen > FMT_BYTES ? clen - FMT_BYTES : '0);
				end
			end
			PH_SKIP: begin
				fcount = fcount - 32'd1;
				if (fcount == '0)
					after_skip();
			end
			PH_PAD: begin
				next_tag();
			end
			PH_DATA: begin
				if (fcount == '0) begin
					lo_byte = b;
					fcount = 32'd1;
					data_left = data_left - 32'd1;
					if (data_left == '0 || eof)
						ph = PH_DONE;
				end else begin
					data_left = data_left - 32'd1;
					fcount = '0;
					fin = (data_left < 32'd2) || eof;
					if (fin)
						ph = PH_DONE;
					r.kind = EV_SAMPLE;
					r.code = ST_OK;
					r.smp = {b, lo_byte};
					r.fin = fin;
					return 1'b1;
				end
			end
			default: begin
				ph = PH_DONE;
			end
		endcase
		// end of file before the samples start
		if (eof && ph != PH_DONE && ph != PH_DATA) begin
			r = fail_result((ph <= PH_WAVE) ? ST_BAD_TAG : ST_NO_DATA);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_cnt < MAX_PRINTS)
			$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// stream building
	task automatic push_byte(input logic [7:0] b, input logic last = 1'b0);
		file_q.push_back('{value: b, last: last});
	endtask

	task automatic push_word32(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			push_byte(w[8*i +: 8]);
	endtask

	// chunk the parser skips whole
	task automatic push_other_chunk(input logic [31:0] len);
		logic [31:0] tag;
		do
			tag = $urandom();
		while (tag == TAG_FMT || tag == TAG_DATA);
		push_word32(tag);
		push_word32(len);
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom()));
		if (len[0])
			push_byte(8'($urandom()));
	endtask

	task automatic push_fmt_chunk(input logic [31:0] len, input logic [15:0] channels,
			input logic [31:0] rate, input logic [31:0] brate);
		push_word32(TAG_FMT);
		push_word32(len);
		push_byte(8'($urandom()));
		push_byte(8'($urandom()));
		push_byte(channels[7:0]);
		push_byte(channels[15:8]);
		push_word32(rate);
		push_word32(brate);
		for (int i = 12; i < len; i++)
			push_byte(8'($urandom()));
		if (len[0])
			push_byte(8'($urandom()));
	endtask

	// sender stalls until every transaction is out and the pipeline is empty
	task automatic wait_drained();
		while (file_q.size() != 0 || in_valid || results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_format_regs(input logic [31:0] rate, input logic [15:0] channels);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_RATE;
		cfg_data <= rate;
		want_rate = rate;
		@(posedge clk);
		cfg_index <= CFG_CHANNELS;
		cfg_data <= 32'(channels);
		want_channels = channels;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// sender: one byte per transaction, random idle bursts
	int gap_left = 0;
	file_byte_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			end_of_file <= 1'b0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (!quiet && file_q.size() != 0 && $urandom_range(0, 15) == 0) begin
				gap_left <= $urandom_range(1, 11) - 1;
				in_valid <= 1'b0;
			end else if (file_q.size() != 0) begin
				next_item = file_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_item.value;
				end_of_file <= next_item.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	int stall_left = 0;
	int taken = 0;
	bit long_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			taken <= 0;
			long_done <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				taken <= taken + 1;
			if (!long_done && taken == LONG_HOLD_AT) begin
				long_done <= 1'b1;
				stall_left <= LONG_HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// predict on each accepted byte, check each result transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready && parse_byte(data_byte, end_of_file, predicted))
				results_q.push_back(predicted);
			if (out_valid && out_ready) begin
				if (results_q.size() == 0) begin
					report_mismatch("unexpected transaction, event", 32'(event_res), '0);
				end else begin
					oldest = results_q.pop_front();
					if (event_res !== oldest.kind)
						report_mismatch("event_res", 32'(event_res), 32'(oldest.kind));
					if (status !== oldest.code)
						report_mismatch("status", 32'(status), 32'(oldest.code));
					if (sample !== oldest.smp)
						report_mismatch("sample", 32'(sample), 32'(oldest.smp));
					if (data_bytes !== oldest.nbytes)
						report_mismatch("data_bytes", data_bytes, oldest.nbytes);
					if (byte_rate !== oldest.brate)
						report_mismatch("byte_rate", byte_rate, oldest.brate);
					if (final_sample !== oldest.fin)
						report_mismatch("final_sample", 32'(final_sample), 32'(oldest.fin));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout with %0d transactions outstanding", results_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		int          mode;
		int          sent_len;
		logic [31:0] data_len;
		logic [31:0] rate;
		logic [15:0] channels;
		logic [31:0] brate;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lowest register values, odd skipped chunk, long fmt, empty chunk
		set_format_regs('0, '0);
		push_word32(TAG_RIFF);
		push_word32($urandom());
		push_word32(TAG_WAVE);
		push_other_chunk(32'd3);
		push_fmt_chunk(32'd16, '0, '0, 32'($urandom()) | 32'd1);
		push_other_chunk('0);
		wait_drained();

		// highest register values, short odd fmt chunk
		set_format_regs('1, '1);
		push_fmt_chunk(32'd11, '1, '1, '1);
		wait_drained();

		// random settings with random chunk layouts
		for (int k = 0; k < 3; k++) begin
			rate = $urandom();
			channels = 16'($urandom());
			brate = $urandom();
			if (brate == '0)
				brate = 32'd1;
			set_format_regs(rate, channels);
			repeat ($urandom_range(2, 4))
				push_other_chunk($urandom_range(0, 24));
			push_fmt_chunk($urandom_range(12, 30), channels, rate, brate);
			wait_drained();
		end

		// data chunk: ends on its size, odd size, or an early end of file
		mode = $urandom_range(0, 3);
		sent_len = $urandom_range(450, 550) * 2;
		if (mode == 1 || mode == 3)
			sent_len++;
		data_len = sent_len;
		if (mode >= 2)
			data_len = data_len + $urandom_range(1, 50);
		push_word32(TAG_DATA);
		push_word32(data_len);
		for (int i = 0; i < sent_len; i++) begin
			// halfway through the samples the sender waits for all results
			if (i == sent_len / 2)
				wait_drained();
			case (i)
				0, 1, 4: push_byte(8'h00, i == sent_len - 1);
				2, 6, 7: push_byte(8'hff, i == sent_len - 1);
				3:       push_byte(8'h7f, i == sent_len - 1);
				5:       push_byte(8'h80, i == sent_len - 1);
				default: push_byte(8'($urandom()), i == sent_len - 1);
			endcase
		end

		// no idling near the end of the stream
		while (file_q.size() > QUIET_TAIL)
			@(negedge clk);
		quiet = 1'b1;

		// bytes after the last sample are dropped
		repeat (10)
			push_byte(8'($urandom()), 1'($urandom()));
		wait_drained();

		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
